/* src/fpsu_pkg.sv */
// Shared types and constants of the fixed-point scientific unit.
package fpsu_pkg;

    localparam logic [63:0] C_ONE      = 64'h0000_0001_0000_0000;
    localparam logic [63:0] C_HALF     = 64'h0000_0000_8000_0000;
    localparam logic [63:0] C_NHALF    = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] C_TWO      = 64'h0000_0002_0000_0000;
    localparam logic [63:0] C_PI       = 64'd13493037705;
    localparam logic [63:0] C_TWOPI    = 64'd26986075410;
    localparam logic [63:0] C_HALFPI   = 64'd6746518852;
    localparam logic [63:0] C_NPI      = ~C_PI + 64'd1;
    localparam logic [63:0] C_NHALFPI  = ~C_HALFPI + 64'd1;
    localparam logic [63:0] C_LN2      = 64'd2977044472;
    localparam logic [63:0] C_LN10     = 64'd9890190863;
    localparam logic [63:0] C_HUNDRED  = 64'h0000_0064_0000_0000;
    localparam logic [63:0] C_DEG_HALF = 64'd180;

    localparam logic [6:0]  C_MUL_STEPS  = 7'd64;
    localparam logic [6:0]  C_DIV_STEPS  = 7'd96;
    localparam logic [5:0]  C_SIN_TERMS  = 6'd9;
    localparam logic [5:0]  C_LN_TERMS   = 6'd13;
    localparam logic [5:0]  C_EXP_TERMS  = 6'd13;
    localparam logic [5:0]  C_SQRT_LAST  = 6'd39;
    localparam int          C_EXP_MAX    = 30;
    localparam int          C_EXP_MIN    = -63;

    localparam logic        REG_ANGLE    = 1'b0;

    typedef enum logic [4:0] {
        OP_ADD     = 5'd0,
        OP_SUB     = 5'd1,
        OP_MUL     = 5'd2,
        OP_DIV     = 5'd3,
        OP_POW     = 5'd4,
        OP_SIN     = 5'd5,
        OP_COS     = 5'd6,
        OP_TAN     = 5'd7,
        OP_LN      = 5'd8,
        OP_LOG     = 5'd9,
        OP_SQRT    = 5'd10,
        OP_SQUARE  = 5'd11,
        OP_RECIP   = 5'd12,
        OP_EXP     = 5'd13,
        OP_NEG     = 5'd14,
        OP_PERCENT = 5'd15,
        OP_PI      = 5'd16
    } t_op;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic        qmode;
        logic [63:0] a;
        logic [63:0] b;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic        dz;
        logic [63:0] res;
    } t_unit_rsp;

endpackage

/* src/fpsu_if.sv */
// Valid/ready word channels of the fixed-point scientific unit.
interface fpsu_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         op;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

interface fpsu_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result;
    logic               error;

    modport source (output valid, output result, output error, input ready);
    modport sink   (input valid, input result, input error, output ready);
endinterface

/* src/fpsu_mul.sv */
// Bit-serial signed Q32.32 multiplier, one multiplier bit per cycle.
module fpsu_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpsu_pkg::t_mul_req   i_req,
    output fpsu_pkg::t_unit_rsp  o_rsp
);
    import fpsu_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic [63:0] r_x, n_x;
    logic [63:0] r_hi, n_hi;
    logic [63:0] r_y, n_y;
    logic [63:0] r_res, n_res;
    logic [64:0] w_sum;
    logic [63:0] w_p;

    assign w_sum = {1'b0, r_hi} + (r_y[0] ? {1'b0, r_x} : 65'd0);
    assign w_p   = {r_hi[31:0], r_y[63:32]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_x    = r_x;
        n_hi   = r_hi;
        n_y    = r_y;
        n_res  = r_res;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_req.a[63] ^ i_req.b[63];
            n_x    = i_req.a[63] ? (~i_req.a + 64'd1) : i_req.a;
            n_y    = i_req.b[63] ? (~i_req.b + 64'd1) : i_req.b;
            n_hi   = '0;
        end else if (r_busy) begin
            if (r_cnt == C_MUL_STEPS) begin
                n_res  = r_neg ? (~w_p + 64'd1) : w_p;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_hi  = w_sum[64:1];
                n_y   = {w_sum[0], r_y[63:1]};
                n_cnt = r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_x   <= n_x;
        r_hi  <= n_hi;
        r_y   <= n_y;
        r_res <= n_res;
    end

    assign o_rsp = '{busy: r_busy, done: r_done, dz: 1'b0, res: r_res};

endmodule

/* src/fpsu_div.sv */
// Bit-serial signed restoring divider, Q32.32 or integer quotient.
module fpsu_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpsu_pkg::t_div_req   i_req,
    output fpsu_pkg::t_unit_rsp  o_rsp
);
    import fpsu_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_dz, n_dz;
    logic [63:0] r_ub, n_ub;
    logic [63:0] r_rem, n_rem;
    logic [95:0] r_z, n_z;
    logic [63:0] r_res, n_res;
    logic [63:0] w_ua;
    logic [64:0] w_t;
    logic [64:0] w_diff;
    logic        w_ge;

    assign w_ua   = i_req.a[63] ? (~i_req.a + 64'd1) : i_req.a;
    assign w_t    = {r_rem, r_z[95]};
    assign w_diff = w_t - {1'b0, r_ub};
    assign w_ge   = w_t >= {1'b0, r_ub};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_dz   = r_dz;
        n_ub   = r_ub;
        n_rem  = r_rem;
        n_z    = r_z;
        n_res  = r_res;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_req.a[63] ^ i_req.b[63];
            n_dz   = (i_req.b == 64'd0);
            n_ub   = i_req.b[63] ? (~i_req.b + 64'd1) : i_req.b;
            n_rem  = '0;
            n_z    = i_req.qmode ? {w_ua, 32'd0} : {32'd0, w_ua};
        end else if (r_busy) begin
            if (r_cnt == C_DIV_STEPS) begin
                n_res  = r_neg ? (~r_z[63:0] + 64'd1) : r_z[63:0];
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_rem = w_ge ? w_diff[63:0] : w_t[63:0];
                n_z   = {r_z[94:0], w_ge};
                n_cnt = r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_dz  <= n_dz;
        r_ub  <= n_ub;
        r_rem <= n_rem;
        r_z   <= n_z;
        r_res <= n_res;
    end

    assign o_rsp = '{busy: r_busy, done: r_done, dz: r_dz, res: r_res};

endmodule

/* src/fixed_point_scientific_unit.sv */
// Q32.32 scientific unit: a sequencer over one serial multiplier and one serial divider.
// Takes one word at a time and returns one result word with an error flag. Add, subtract,
// negate and pi need neither unit; a multiply runs on the 64-step multiplier and a divide on
// the 96-step divider. Series functions such as sin, cos, tan, ln, exp and power chain these.
// A new word is taken once the previous one has reached the output register.
module fixed_point_scientific_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpsu_in_if.sink     i_in,
    fpsu_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpsu_pkg::*;

    typedef enum logic [35:0] {
        ST_IDLE = 36'h1 << 0,
        ST_DISP = 36'h1 << 1,
        ST_MUL  = 36'h1 << 2,
        ST_DIV  = 36'h1 << 3,
        ST_GMUL = 36'h1 << 4,
        ST_GDIV = 36'h1 << 5,
        ST_GSUM = 36'h1 << 6,
        ST_FIN  = 36'h1 << 7,
        ST_RAD1 = 36'h1 << 8,
        ST_RAD2 = 36'h1 << 9,
        ST_TRIG = 36'h1 << 10,
        ST_TAN1 = 36'h1 << 11,
        ST_TAN2 = 36'h1 << 12,
        ST_SIN0 = 36'h1 << 13,
        ST_SIN1 = 36'h1 << 14,
        ST_SIN2 = 36'h1 << 15,
        ST_SIN3 = 36'h1 << 16,
        ST_SIN4 = 36'h1 << 17,
        ST_SIN5 = 36'h1 << 18,
        ST_LNN  = 36'h1 << 19,
        ST_LN1  = 36'h1 << 20,
        ST_LN2  = 36'h1 << 21,
        ST_LN3  = 36'h1 << 22,
        ST_LN4  = 36'h1 << 23,
        ST_LN5  = 36'h1 << 24,
        ST_LOG1 = 36'h1 << 25,
        ST_POW1 = 36'h1 << 26,
        ST_POW2 = 36'h1 << 27,
        ST_EX0  = 36'h1 << 28,
        ST_EX1  = 36'h1 << 29,
        ST_EX2  = 36'h1 << 30,
        ST_EX3  = 36'h1 << 31,
        ST_EX4  = 36'h1 << 32,
        ST_EXS  = 36'h1 << 33,
        ST_SQ1  = 36'h1 << 34,
        ST_SQ2  = 36'h1 << 35
    } t_state;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    t_state      r_sret, n_sret;
    logic [4:0]  r_op, n_op;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_x, n_x;
    logic [63:0] r_t2, n_t2;
    logic [63:0] r_term, n_term;
    logic [63:0] r_sum, n_sum;
    logic [63:0] r_res, n_res;
    logic [6:0]  r_e, n_e;
    logic [6:0]  r_k, n_k;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_fault, n_fault;
    logic        r_angle;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_oresult, n_oresult;
    logic        r_oerror, n_oerror;
    t_mul_req    r_mreq, n_mreq;
    t_div_req    r_dreq, n_dreq;
    t_unit_rsp   w_mrsp, w_drsp;

    logic [63:0] w_mres, w_dres;
    logic [63:0] w_rnd, w_kq, w_xr, w_f1, w_f2, w_sq, w_nr;
    logic [31:0] w_kk;
    logic [4:0]  w_k2;
    logic [9:0]  w_sdiv;

    fpsu_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_mreq), .o_rsp(w_mrsp));
    fpsu_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_dreq), .o_rsp(w_drsp));

    assign w_mres = w_mrsp.res;
    assign w_dres = w_drsp.res;
    assign w_rnd  = w_dres + (w_dres[63] ? C_NHALF : C_HALF);
    assign w_kq   = w_dres + (r_x[63] ? C_NHALF : C_HALF);
    assign w_kk   = w_kq[63:32];
    assign w_xr   = r_x - w_mres;
    assign w_f1   = ($signed(w_xr) > $signed(C_HALFPI)) ? (C_PI - w_xr) : w_xr;
    assign w_f2   = ($signed(w_f1) < $signed(C_NHALFPI)) ? (C_NPI - w_f1) : w_f1;
    assign w_sq   = r_term + w_dres;
    assign w_nr   = {w_sq[63], w_sq[63:1]};
    assign w_k2   = {r_cnt[3:0], 1'b0};
    assign w_sdiv = 10'(w_k2) * (10'(w_k2) + 10'd1);

    assign i_in.ready   = (r_state == ST_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.result = r_oresult;
    assign o_out.error  = r_oerror;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ANGLE) ? {31'd0, r_angle} : 32'd0;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_sret    = r_sret;
        n_op      = r_op;
        n_a       = r_a;
        n_b       = r_b;
        n_x       = r_x;
        n_t2      = r_t2;
        n_term    = r_term;
        n_sum     = r_sum;
        n_res     = r_res;
        n_e       = r_e;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_fault   = r_fault;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_oresult = r_oresult;
        n_oerror  = r_oerror;
        n_mreq    = '{start: 1'b0, a: r_mreq.a, b: r_mreq.b};
        n_dreq    = '{start: 1'b0, qmode: r_dreq.qmode, a: r_dreq.a, b: r_dreq.b};

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.op;
                    n_a     = i_in.operand_a;
                    n_b     = i_in.operand_b;
                    n_fault = 1'b0;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_state = ST_FIN;
                case (r_op)
                    OP_ADD:  n_res = r_a + r_b;
                    OP_SUB:  n_res = r_a - r_b;
                    OP_NEG:  n_res = ~r_a + 64'd1;
                    OP_PI:   n_res = C_PI;
                    OP_MUL: begin
                        n_mreq = '{start: 1'b1, a: r_a, b: r_b};
                        n_ret = ST_GMUL; n_state = ST_MUL;
                    end
                    OP_SQUARE: begin
                        n_mreq = '{start: 1'b1, a: r_a, b: r_a};
                        n_ret = ST_GMUL; n_state = ST_MUL;
                    end
                    OP_DIV: begin
                        n_dreq = '{start: 1'b1, qmode: 1'b1, a: r_a, b: r_b};
                        n_ret = ST_GDIV; n_state = ST_DIV;
                    end
                    OP_RECIP: begin
                        n_dreq = '{start: 1'b1, qmode: 1'b1, a: C_ONE, b: r_a};
                        n_ret = ST_GDIV; n_state = ST_DIV;
                    end
                    OP_PERCENT: begin
                        n_dreq = '{start: 1'b1, qmode: 1'b1, a: r_a, b: C_HUNDRED};
                        n_ret = ST_GDIV; n_state = ST_DIV;
                    end
                    OP_LN, OP_LOG, OP_POW: begin
                        if ($signed(r_a) <= 0) begin
                            n_fault = 1'b1;
                        end else begin
                            n_x = r_a;
                            n_e = '0;
                            n_state = ST_LNN;
                            case (r_op)
                                OP_LN:   n_sret = ST_GSUM;
                                OP_LOG:  n_sret = ST_LOG1;
                                default: n_sret = ST_POW1;
                            endcase
                        end
                    end
                    OP_EXP: begin
                        n_x = r_a; n_sret = ST_GSUM; n_state = ST_EX0;
                    end
                    OP_SQRT: begin
                        if (r_a[63]) begin
                            n_fault = 1'b1;
                        end else if (r_a == 64'd0) begin
                            n_res = '0;
                        end else begin
                            n_term = ($signed(r_a) > $signed(C_ONE)) ? r_a : C_ONE;
                            n_cnt = '0;
                            n_state = ST_SQ1;
                        end
                    end
                    OP_SIN, OP_COS, OP_TAN: begin
                        if (r_angle) begin
                            n_mreq = '{start: 1'b1, a: r_a, b: C_PI};
                            n_ret = ST_RAD1; n_state = ST_MUL;
                        end else begin
                            n_x = r_a; n_state = ST_TRIG;
                        end
                    end
                    default: n_fault = 1'b1;
                endcase
            end
            ST_MUL: begin
                if (w_mrsp.done) n_state = r_ret;
            end
            ST_DIV: begin
                if (w_drsp.done) begin
                    if (w_drsp.dz) begin
                        n_fault = 1'b1; n_state = ST_FIN;
                    end else begin
                        n_state = r_ret;
                    end
                end
            end
            ST_GMUL: begin
                n_res = w_mres; n_state = ST_FIN;
            end
            ST_GDIV: begin
                n_res = w_dres; n_state = ST_FIN;
            end
            ST_GSUM: begin
                n_res = r_sum; n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_oresult = r_fault ? 64'd0 : r_res;
                    n_oerror  = r_fault;
                    n_state   = ST_IDLE;
                end
            end
            ST_RAD1: begin
                n_dreq = '{start: 1'b1, qmode: 1'b0, a: w_mres, b: C_DEG_HALF};
                n_ret = ST_RAD2; n_state = ST_DIV;
            end
            ST_RAD2: begin
                n_x = w_dres; n_state = ST_TRIG;
            end
            ST_TRIG: begin
                n_state = ST_SIN0;
                case (r_op)
                    OP_SIN: n_sret = ST_GSUM;
                    OP_COS: begin
                        n_x = r_x + C_HALFPI; n_sret = ST_GSUM;
                    end
                    default: begin
                        n_a = r_x; n_x = r_x + C_HALFPI; n_sret = ST_TAN1;
                    end
                endcase
            end
            ST_TAN1: begin
                if (r_sum == 64'd0) begin
                    n_fault = 1'b1; n_state = ST_FIN;
                end else begin
                    n_b = r_sum; n_x = r_a; n_sret = ST_TAN2; n_state = ST_SIN0;
                end
            end
            ST_TAN2: begin
                n_dreq = '{start: 1'b1, qmode: 1'b1, a: r_sum, b: r_b};
                n_ret = ST_GDIV; n_state = ST_DIV;
            end
            ST_SIN0: begin
                n_dreq = '{start: 1'b1, qmode: 1'b1, a: r_x, b: C_TWOPI};
                n_ret = ST_SIN1; n_state = ST_DIV;
            end
            ST_SIN1: begin
                n_mreq = '{start: 1'b1, a: {w_rnd[63:32], 32'd0}, b: C_TWOPI};
                n_ret = ST_SIN2; n_state = ST_MUL;
            end
            ST_SIN2: begin
                n_x = w_f2;
                n_mreq = '{start: 1'b1, a: w_f2, b: w_f2};
                n_ret = ST_SIN3; n_state = ST_MUL;
            end
            ST_SIN3: begin
                n_t2 = w_mres; n_term = r_x; n_sum = r_x; n_cnt = 6'd1;
                n_mreq = '{start: 1'b1, a: r_x, b: w_mres};
                n_ret = ST_SIN4; n_state = ST_MUL;
            end
            ST_SIN4: begin
                n_dreq = '{start: 1'b1, qmode: 1'b0, a: ~w_mres + 64'd1, b: {54'd0, w_sdiv}};
                n_ret = ST_SIN5; n_state = ST_DIV;
            end
            ST_SIN5: begin
                n_term = w_dres;
                n_sum = r_sum + w_dres;
                if (r_cnt == C_SIN_TERMS) begin
                    n_state = r_sret;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                    n_mreq = '{start: 1'b1, a: w_dres, b: r_t2};
                    n_ret = ST_SIN4; n_state = ST_MUL;
                end
            end
            ST_LNN: begin
                if (r_x >= C_TWO) begin
                    n_x = {1'b0, r_x[63:1]}; n_e = r_e + 7'd1;
                end else if (r_x < C_ONE) begin
                    n_x = {r_x[62:0], 1'b0}; n_e = r_e - 7'd1;
                end else begin
                    n_dreq = '{start: 1'b1, qmode: 1'b1, a: r_x - C_ONE, b: r_x + C_ONE};
                    n_ret = ST_LN1; n_state = ST_DIV;
                end
            end
            ST_LN1: begin
                n_term = w_dres; n_sum = w_dres;
                n_mreq = '{start: 1'b1, a: w_dres, b: w_dres};
                n_ret = ST_LN2; n_state = ST_MUL;
            end
            ST_LN2: begin
                n_t2 = w_mres; n_cnt = 6'd1;
                n_mreq = '{start: 1'b1, a: r_term, b: w_mres};
                n_ret = ST_LN3; n_state = ST_MUL;
            end
            ST_LN3: begin
                n_term = w_mres;
                n_dreq = '{start: 1'b1, qmode: 1'b0, a: w_mres, b: {59'd0, r_cnt[3:0], 1'b1}};
                n_ret = ST_LN4; n_state = ST_DIV;
            end
            ST_LN4: begin
                n_sum = r_sum + w_dres;
                if (r_cnt == C_LN_TERMS) begin
                    n_mreq = '{start: 1'b1, a: {{25{r_e[6]}}, r_e, 32'd0}, b: C_LN2};
                    n_ret = ST_LN5; n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                    n_mreq = '{start: 1'b1, a: r_term, b: r_t2};
                    n_ret = ST_LN3; n_state = ST_MUL;
                end
            end
            ST_LN5: begin
                n_sum = w_mres + {r_sum[62:0], 1'b0};
                n_state = r_sret;
            end
            ST_LOG1: begin
                n_dreq = '{start: 1'b1, qmode: 1'b1, a: r_sum, b: C_LN10};
                n_ret = ST_GDIV; n_state = ST_DIV;
            end
            ST_POW1: begin
                n_mreq = '{start: 1'b1, a: r_b, b: r_sum};
                n_ret = ST_POW2; n_state = ST_MUL;
            end
            ST_POW2: begin
                n_x = w_mres; n_sret = ST_GSUM; n_state = ST_EX0;
            end
            ST_EX0: begin
                n_dreq = '{start: 1'b1, qmode: 1'b1, a: r_x, b: C_LN2};
                n_ret = ST_EX1; n_state = ST_DIV;
            end
            ST_EX1: begin
                if ($signed(w_kk) > C_EXP_MAX) begin
                    n_fault = 1'b1; n_state = ST_FIN;
                end else if ($signed(w_kk) < C_EXP_MIN) begin
                    n_sum = '0; n_state = r_sret;
                end else begin
                    n_k = w_kk[6:0];
                    n_mreq = '{start: 1'b1, a: {w_kk, 32'd0}, b: C_LN2};
                    n_ret = ST_EX2; n_state = ST_MUL;
                end
            end
            ST_EX2: begin
                n_t2 = w_xr; n_term = C_ONE; n_sum = C_ONE; n_cnt = 6'd1;
                n_mreq = '{start: 1'b1, a: C_ONE, b: w_xr};
                n_ret = ST_EX3; n_state = ST_MUL;
            end
            ST_EX3: begin
                n_dreq = '{start: 1'b1, qmode: 1'b0, a: w_mres, b: {58'd0, r_cnt}};
                n_ret = ST_EX4; n_state = ST_DIV;
            end
            ST_EX4: begin
                n_term = w_dres;
                n_sum = r_sum + w_dres;
                if (r_cnt == C_EXP_TERMS) begin
                    n_state = ST_EXS;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                    n_mreq = '{start: 1'b1, a: w_dres, b: r_t2};
                    n_ret = ST_EX3; n_state = ST_MUL;
                end
            end
            ST_EXS: begin
                if (r_k == 7'd0) begin
                    n_state = r_sret;
                end else if (!r_k[6]) begin
                    n_sum = {r_sum[62:0], 1'b0}; n_k = r_k - 7'd1;
                end else begin
                    n_sum = {r_sum[63], r_sum[63:1]}; n_k = r_k + 7'd1;
                end
            end
            ST_SQ1: begin
                n_dreq = '{start: 1'b1, qmode: 1'b1, a: r_a, b: r_term};
                n_ret = ST_SQ2; n_state = ST_DIV;
            end
            ST_SQ2: begin
                if (w_nr == r_term) begin
                    n_res = r_term; n_state = ST_FIN;
                end else if (r_cnt == C_SQRT_LAST) begin
                    n_res = w_nr; n_state = ST_FIN;
                end else begin
                    n_term = w_nr; n_cnt = r_cnt + 6'd1; n_state = ST_SQ1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_IDLE;
            r_sret       <= ST_IDLE;
            r_fault      <= 1'b0;
            r_angle      <= 1'b0;
            r_ovalid     <= 1'b0;
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_sret   <= n_sret;
            r_fault  <= n_fault;
            r_ovalid <= n_ovalid;
            r_mreq.start <= n_mreq.start;
            r_dreq.start <= n_dreq.start;
            if (psel && penable && pwrite && paddr[2] == REG_ANGLE) begin
                r_angle <= pwdata[0];
            end
        end
        r_op         <= n_op;
        r_a          <= n_a;
        r_b          <= n_b;
        r_x          <= n_x;
        r_t2         <= n_t2;
        r_term       <= n_term;
        r_sum        <= n_sum;
        r_res        <= n_res;
        r_e          <= n_e;
        r_k          <= n_k;
        r_cnt        <= n_cnt;
        r_oresult    <= n_oresult;
        r_oerror     <= n_oerror;
        r_mreq.a     <= n_mreq.a;
        r_mreq.b     <= n_mreq.b;
        r_dreq.qmode <= n_dreq.qmode;
        r_dreq.a     <= n_dreq.a;
        r_dreq.b     <= n_dreq.b;
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error) |-> (o_out.result == 64'sd0))
        else $error("error word carries a non-zero result");

    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_DISP))
        else $error("accepted word not dispatched");

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mreq.start |-> !w_mrsp.busy)
        else $error("multiplier started while busy");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dreq.start |-> !w_drsp.busy)
        else $error("divider started while busy");

endmodule

/* bench/fixed_point_scientific_unit_test.sv */
// Self-checking bench for the Q32.32 scientific unit: directed and random words, checked against a predictor.
`timescale 1ns / 1ps

module fixed_point_scientific_unit_test;
    import fpsu_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic        error;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fpsu_in_if  in_ch ();
    fpsu_out_if out_ch ();

    fixed_point_scientific_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_answer     answers_due[$];
    int          mismatches = 0;
    int          out_wait = 0;
    logic        degrees_mode = 1'b0;
    logic        calc_fault;
    bit          sender_idles = 1'b1;
    bit          receiver_idles = 1'b1;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic logic is_neg(logic [63:0] v);
        return v[63];
    endfunction

    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic s_lt(logic [63:0] a, logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [63:0] asr(logic [63:0] v, logic [63:0] n);
        if (n >= 64) return v[63] ? '1 : '0;
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] div_const(logic [63:0] v, logic [63:0] d);
        logic [63:0] q;
        q = mag(v) / d;
        return v[63] ? -q : q;
    endfunction

    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        logic [63:0]  r;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        r = p[95:32];
        return (a[63] != b[63]) ? -r : r;
    endfunction

    function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
        logic [95:0] q;
        if (b == 0) begin
            calc_fault = 1'b1;
            return '0;
        end
        q = {mag(a), 32'd0} / {32'd0, mag(b)};
        return (a[63] != b[63]) ? -q[63:0] : q[63:0];
    endfunction

    function automatic logic [63:0] fx_sqrt(logic [63:0] x);
        logic [63:0] r, nr;
        if (x[63]) begin
            calc_fault = 1'b1;
            return '0;
        end
        if (x == 0) return '0;
        r = s_lt(C_ONE, x) ? x : C_ONE;
        for (int i = 0; i < 40; i++) begin
            nr = asr(r + fx_div(x, r), 1);
            if (nr == r) break;
            r = nr;
        end
        return r;
    endfunction

    function automatic logic [63:0] round_whole(logic [63:0] q, logic nonneg);
        return asr(q + (nonneg ? C_HALF : C_NHALF), 32);
    endfunction

    function automatic logic [63:0] fx_sin(logic [63:0] x);
        logic [63:0] n, x2, term, sum;
        n = round_whole(fx_div(x, C_TWOPI), !is_neg(fx_div(x, C_TWOPI)));
        x = x - n * C_TWOPI;
        if (s_lt(C_HALFPI, x)) x = C_PI - x;
        if (s_lt(x, C_NHALFPI)) x = C_NPI - x;
        x2 = fx_mul(x, x);
        term = x;
        sum = x;
        for (int k = 1; k < 10; k++) begin
            term = div_const(-fx_mul(term, x2), 64'((2 * k) * (2 * k + 1)));
            sum += term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] fx_tan(logic [63:0] x);
        logic [63:0] c;
        c = fx_sin(x + C_HALFPI);
        if (c == 0) begin
            calc_fault = 1'b1;
            return '0;
        end
        return fx_div(fx_sin(x), c);
    endfunction

    function automatic logic [63:0] fx_ln(logic [63:0] x);
        logic [63:0] e, t, t2, term, sum;
        e = '0;
        if (x[63] || x == 0) begin
            calc_fault = 1'b1;
            return '0;
        end
        while (x >= C_TWO) begin
            x >>= 1;
            e++;
        end
        while (x < C_ONE) begin
            x <<= 1;
            e--;
        end
        t = fx_div(x - C_ONE, x + C_ONE);
        t2 = fx_mul(t, t);
        term = t;
        sum = t;
        for (int k = 1; k < 14; k++) begin
            term = fx_mul(term, t2);
            sum += div_const(term, 64'(2 * k + 1));
        end
        return e * C_LN2 + (sum << 1);
    endfunction

    function automatic logic [63:0] fx_exp(logic [63:0] x);
        logic [63:0] k, r, term, sum, sh;
        k = round_whole(fx_div(x, C_LN2), !x[63]);
        if (s_lt(64'(C_EXP_MAX), k)) begin
            calc_fault = 1'b1;
            return '0;
        end
        r = x - k * C_LN2;
        term = C_ONE;
        sum = C_ONE;
        for (int i = 1; i < 14; i++) begin
            term = div_const(fx_mul(term, r), 64'(i));
            sum += term;
        end
        if (!k[63]) return sum << k;
        sh = 64'd0 - k;
        if (sh >= 64) return '0;
        return asr(sum, sh);
    endfunction

    function automatic logic [63:0] fx_pow(logic [63:0] a, logic [63:0] b);
        if (a[63] || a == 0) begin
            calc_fault = 1'b1;
            return '0;
        end
        return fx_exp(fx_mul(b, fx_ln(a)));
    endfunction

    function automatic logic [63:0] angle_rad(logic [63:0] v);
        return degrees_mode ? div_const(fx_mul(v, C_PI), C_DEG_HALF) : v;
    endfunction

    function automatic t_answer compute_answer(logic [4:0] op, logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        calc_fault = 1'b0;
        r = '0;
        case (op)
            OP_ADD:     r = a + b;
            OP_SUB:     r = a - b;
            OP_MUL:     r = fx_mul(a, b);
            OP_DIV:     r = fx_div(a, b);
            OP_POW:     r = fx_pow(a, b);
            OP_SIN:     r = fx_sin(angle_rad(a));
            OP_COS:     r = fx_sin(angle_rad(a) + C_HALFPI);
            OP_TAN:     r = fx_tan(angle_rad(a));
            OP_LN:      r = fx_ln(a);
            OP_LOG:     r = fx_div(fx_ln(a), C_LN10);
            OP_SQRT:    r = fx_sqrt(a);
            OP_SQUARE:  r = fx_mul(a, a);
            OP_RECIP:   r = fx_div(C_ONE, a);
            OP_EXP:     r = fx_exp(a);
            OP_NEG:     r = -a;
            OP_PERCENT: r = fx_div(a, C_HUNDRED);
            OP_PI:      r = C_PI;
            default:    calc_fault = 1'b1;
        endcase
        return '{value: calc_fault ? 64'd0 : r, error: calc_fault};
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic send_word(logic [4:0] op, logic [63:0] a, logic [63:0] b);
        int gap;
        gap = sender_idles ? $urandom_range(13, 0) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        answers_due.push_back(compute_answer(op, a, b));
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_angle_mode(logic deg);
        settle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(REG_ANGLE) * 3'd4;
        pwdata <= {31'd0, deg};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        degrees_mode = deg;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait = 0;
        end else if (out_ch.ready) begin
            if (out_ch.valid) begin
                out_wait = receiver_idles ? $urandom_range(13, 0) : 0;
                if (out_wait > 0) out_ch.ready <= 1'b0;
            end
        end else if (out_wait > 1) begin
            out_wait--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %h err %b", out_ch.result,
                                               out_ch.error);
            end else begin
                want = answers_due.pop_front();
                if (out_ch.result !== want.value || out_ch.error !== want.error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h err %b, got %h err %b",
                                 want.value, want.error, out_ch.result, out_ch.error);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_operand(logic [4:0] op);
        logic [63:0] v;
        case ($urandom_range(5, 0))
            0:       v = rand64();
            1, 2:    v = {{28{1'b0}}, 36'(rand64())};
            3:       v = {{30{1'b0}}, 34'(rand64())};
            default: v = {{24{1'b0}}, 40'(rand64())};
        endcase
        if ((op == OP_EXP || op == OP_POW) && $urandom_range(3, 0) != 0)
            v = {{30{1'b0}}, 34'(rand64())};
        if ($urandom_range(1, 0) && !(op inside {OP_LN, OP_LOG, OP_SQRT, OP_POW}))
            v = -v;
        if ($urandom_range(9, 0) == 0) v = -v;
        return v;
    endfunction

    task automatic test_arithmetic();
        send_word(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, C_ONE);
        send_word(OP_SUB, 64'h8000_0000_0000_0000, C_ONE);
        send_word(OP_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(OP_MUL, 64'h8000_0000_0000_0000, C_TWO);
        send_word(OP_DIV, C_PI, '0);
        send_word(OP_DIV, -C_PI, C_TWO);
        send_word(OP_RECIP, '0, '0);
        send_word(OP_SQUARE, 64'h0000_0003_8000_0000, '0);
        send_word(OP_NEG, 64'h8000_0000_0000_0000, '0);
        send_word(OP_PERCENT, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_word(OP_PI, '1, '1);
        send_word(5'd17, C_ONE, C_ONE);
        send_word(5'd31, '0, '0);
    endtask

    task automatic test_functions();
        send_word(OP_LN, '0, '0);
        send_word(OP_LOG, -C_ONE, '0);
        send_word(OP_LN, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_word(OP_LOG, 64'd1, '0);
        send_word(OP_SQRT, -C_ONE, '0);
        send_word(OP_SQRT, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_word(OP_POW, '0, C_TWO);
        send_word(OP_POW, C_TWO, 64'h0000_0003_0000_0000);
        send_word(OP_EXP, 64'h0000_0016_0000_0000, '0);
        send_word(OP_EXP, 64'hFFFF_FFD0_0000_0000, '0);
        send_word(OP_EXP, 64'h8000_0000_0000_0000, '0);
    endtask

    task automatic test_trig(logic deg);
        set_angle_mode(deg);
        send_word(OP_SIN, deg ? 64'h0000_005A_0000_0000 : C_HALFPI, '0);
        send_word(OP_COS, deg ? 64'hFFFF_FF4C_0000_0000 : C_NPI, '0);
        send_word(OP_TAN, deg ? 64'h0000_005A_0000_0000 : C_HALFPI, '0);
        send_word(OP_TAN, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_word(OP_SIN, 64'h8000_0000_0000_0000, '0);
    endtask

    task automatic test_random(int count);
        logic [4:0] op;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) begin
                sender_idles = $urandom_range(2, 0) != 0;
                receiver_idles = $urandom_range(2, 0) != 0;
            end
            op = ($urandom_range(19, 0) == 0) ? 5'($urandom_range(31, 17))
                                               : 5'($urandom_range(16, 0));
            send_word(op, rand_operand(op), rand_operand(op));
        end
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_arithmetic();
        test_functions();
        test_trig(1'b0);
        test_trig(1'b1);
        test_random(40);
        set_angle_mode(1'b0);
        test_random(66);
        settle();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #25ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* fixed_point_scientific_unit.f */
src/fpsu_pkg.sv
src/fpsu_if.sv
src/fpsu_mul.sv
src/fpsu_div.sv
src/fixed_point_scientific_unit.sv
bench/fixed_point_scientific_unit_test.sv
